[rtl/core/h264sps_pkg.sv]
// Shared types, constants and helpers for the SPS dimension parser.
`default_nettype none
package h264sps_pkg;

	localparam int unsigned MAX_WIDTH_MBS    = 512;
	localparam int unsigned MAX_HEIGHT_UNITS = 512;
	localparam int unsigned MAX_GOLOMB_ZEROS = 31;
	localparam int unsigned FIFO_DEPTH       = 4;
	localparam int unsigned FIFO_AW          = $clog2(FIFO_DEPTH);

	localparam logic [7:0] EPB_BYTE = 8'h03;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TRUNC     = 3'd1;
	localparam logic [2:0] ST_LONG_CODE = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_OVERSIZE  = 3'd4;

	typedef enum logic [4:0] {
		PH_PROFILE, PH_CONSTRAINT, PH_LEVEL, PH_SPS_ID,
		PH_CHROMA, PH_SEP_PLANE, PH_LUMA_DEPTH, PH_CHROMA_DEPTH, PH_BYPASS,
		PH_MATRIX, PH_LIST_FLAG, PH_DELTA,
		PH_LOG2_FRAME, PH_POC_TYPE, PH_POC_LSB, PH_ZERO_FLAG, PH_OFF_NONREF,
		PH_OFF_TB, PH_CYCLE_LEN, PH_CYCLE_OFF,
		PH_NUM_REF, PH_GAPS, PH_WIDTH, PH_HEIGHT, PH_FRAME_ONLY, PH_MBAFF,
		PH_DIRECT8, PH_CROP_FLAG, PH_CROP, PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [13:0] coded_width;
		logic [14:0] coded_height;
		logic [13:0] visible_width;
		logic [14:0] visible_height;
		logic [12:0] crop_left_px;
		logic [13:0] crop_top_px;
	} out_beat_t;

	// classified byte passed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       feed;
		logic       last;
		logic       short_unit;
	} work_t;

	function automatic logic [3:0] phase_width(input phase_t p);
		case (p)
			PH_PROFILE, PH_CONSTRAINT, PH_LEVEL: phase_width = 4'd8;
			PH_SEP_PLANE, PH_BYPASS, PH_MATRIX, PH_LIST_FLAG, PH_ZERO_FLAG,
			PH_GAPS, PH_FRAME_ONLY, PH_MBAFF, PH_DIRECT8, PH_CROP_FLAG:
				phase_width = 4'd1;
			default: phase_width = 4'd0;
		endcase
	endfunction

	function automatic logic is_high_profile(input logic [7:0] p);
		case (p)
			8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86,
			8'd118, 8'd128, 8'd138, 8'd139, 8'd134, 8'd135: is_high_profile = 1'b1;
			default: is_high_profile = 1'b0;
		endcase
	endfunction

endpackage
`default_nettype wire

[rtl/core/h264sps_front.sv]
// Front end: header skip, emulation-prevention removal, byte counting.
`default_nettype none
module h264sps_front import h264sps_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  in_beat_t      in_data,
	output logic          in_stall,
	output logic          q_valid,
	output work_t         q_data,
	input  wire logic     q_full
);
	logic       header_seen_q;
	logic [1:0] zero_run_q;
	logic [2:0] byte_index_q;
	logic       drop;
	logic [2:0] bidx_n;

	assign in_stall = q_full;
	assign q_valid  = in_valid;
	assign drop     = header_seen_q && zero_run_q == 2'd2 && in_data.data_byte == EPB_BYTE;

	always_comb begin
		bidx_n = byte_index_q;
		if (header_seen_q && !drop && byte_index_q < 3'd4)
			bidx_n = byte_index_q + 3'd1;
	end

	assign q_data.data       = in_data.data_byte;
	assign q_data.feed       = header_seen_q && !drop;
	assign q_data.last       = in_data.last_byte;
	assign q_data.short_unit = bidx_n < 3'd4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_seen_q <= 1'b0;
			zero_run_q    <= 2'd0;
			byte_index_q  <= 3'd0;
		end else if (in_valid && !q_full) begin
			if (in_data.last_byte) begin
				header_seen_q <= 1'b0;
				zero_run_q    <= 2'd0;
				byte_index_q  <= 3'd0;
			end else begin
				header_seen_q <= 1'b1;
				byte_index_q  <= bidx_n;
				if (drop)
					zero_run_q <= 2'd0;
				else if (header_seen_q)
					zero_run_q <= (in_data.data_byte != 8'd0) ? 2'd0 :
						(zero_run_q == 2'd3 ? 2'd3 : zero_run_q + 2'd1);
			end
		end
	end
endmodule
`default_nettype wire

[rtl/core/h264sps_fifo.sv]
// Short queue between front and back.
`default_nettype none
module h264sps_fifo import h264sps_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  work_t     wr_data,
	output logic      full,
	output logic      rd_valid,
	output work_t     rd_data,
	input  wire logic rd_en
);
	work_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q, rp_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               push, pop;

	assign full     = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_en && !full;
	assign pop      = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

[rtl/core/h264sps_back.sv]
// Back end: bit-serial Exp-Golomb parse, end-of-unit drain and size math.
`default_nettype none
module h264sps_back import h264sps_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	input  work_t     q_data,
	output logic      q_pop,
	output logic      out_valid,
	output out_beat_t out_data,
	input  wire logic out_stall
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_BITS  = 6'b000010,
		S_DRAIN = 6'b000100,
		S_CALC1 = 6'b001000,
		S_CALC2 = 6'b010000,
		S_CALC3 = 6'b100000
	} state_t;

	state_t      state_q;
	work_t       cur_q;
	logic [2:0]  bit_q;
	phase_t      phase_q;
	logic [5:0]  gz_q;
	logic [31:0] acc_q;
	logic [5:0]  bl_q;
	logic [7:0]  profile_q;
	logic [1:0]  chroma_q;
	logic        frame_only_q;
	logic [31:0] width_q, height_q;
	logic [31:0] crop_q [4];
	logic [3:0]  list_q;
	logic [6:0]  entry_q;
	logic [7:0]  last_scale_q;
	logic [31:0] cycle_q;
	logic [2:0]  err_q;
	logic        out_full_q;
	out_beat_t   out_q;
	out_beat_t   res_n;
	logic        out_load;

	// calc pipeline registers
	logic [1:0]  ux_s1;
	logic [2:0]  uy_s1;
	logic [33:0] sx_s1, sy_s1;
	logic        big_s1;
	logic [13:0] cw_s1;
	logic [14:0] ch_s1;
	logic [35:0] cx_s2, cy_s2;
	logic [35:0] lx_s2, ty_s2;

	// feed_bit combinational
	logic        b;
	logic        dlv;
	logic [31:0] dv;
	logic [31:0] acc_sh;
	logic        gol;
	logic [31:0] gmask;

	assign gol    = phase_width(phase_q) == 4'd0;
	assign b      = cur_q.data[bit_q];
	assign acc_sh = {acc_q[30:0], b};
	assign gmask  = 32'((33'd1 << gz_q[4:0]) - 33'd1);

	always_comb begin
		dlv = 1'b0;
		dv  = acc_sh;
		if (!gol) begin
			dlv = bl_q == 6'd1;
		end else if (bl_q == 6'd0) begin
			dlv = b && gz_q == 6'd0;
			dv  = '0;
		end else begin
			dlv = bl_q == 6'd1;
			dv  = gmask + acc_sh;
		end
	end

	// next-state of parse for a delivered value
	phase_t      nph;
	logic        set_list0, inc_list, set_scale, chroma_wr, width_wr, height_wr;
	logic        fo_wr, crop_wr, cyc_load, cyc_dec, prof_wr, ent_inc;
	logic [7:0]  ns;
	logic [31:0] dd;
	logic [3:0]  nl;

	always_comb begin
		nph = PH_DONE;
		set_list0 = 1'b0; inc_list = 1'b0; set_scale = 1'b0; chroma_wr = 1'b0;
		width_wr = 1'b0; height_wr = 1'b0; fo_wr = 1'b0; crop_wr = 1'b0;
		cyc_load = 1'b0; cyc_dec = 1'b0; prof_wr = 1'b0; ent_inc = 1'b0;
		dd = dv[0] ? ((dv + 32'd1) >> 1) : (32'd0 - (dv >> 1));
		ns = last_scale_q + dd[7:0];
		nl = list_q + 4'd1;
		case (phase_q)
			PH_PROFILE: begin prof_wr = 1'b1; nph = PH_CONSTRAINT; end
			PH_CONSTRAINT: nph = PH_LEVEL;
			PH_LEVEL: nph = PH_SPS_ID;
			PH_SPS_ID: nph = is_high_profile(profile_q) ? PH_CHROMA : PH_LOG2_FRAME;
			PH_CHROMA: begin
				chroma_wr = 1'b1;
				nph = (dv == 32'd3) ? PH_SEP_PLANE : PH_LUMA_DEPTH;
			end
			PH_SEP_PLANE: nph = PH_LUMA_DEPTH;
			PH_LUMA_DEPTH: nph = PH_CHROMA_DEPTH;
			PH_CHROMA_DEPTH: nph = PH_BYPASS;
			PH_BYPASS: nph = PH_MATRIX;
			PH_MATRIX: begin
				set_list0 = 1'b1;
				nph = dv[0] ? PH_LIST_FLAG : PH_LOG2_FRAME;
			end
			PH_LIST_FLAG: begin
				if (dv[0]) begin
					set_scale = 1'b1;
					nph = PH_DELTA;
				end else begin
					inc_list = 1'b1;
					nph = (nl >= (chroma_q == 2'd3 ? 4'd12 : 4'd8)) ?
						PH_LOG2_FRAME : PH_LIST_FLAG;
				end
			end
			PH_DELTA: begin
				ent_inc = 1'b1;
				if (ns == 8'd0 || (entry_q + 7'd1) >= (list_q < 4'd6 ? 7'd16 : 7'd64)) begin
					inc_list = 1'b1;
					nph = (nl >= (chroma_q == 2'd3 ? 4'd12 : 4'd8)) ?
						PH_LOG2_FRAME : PH_LIST_FLAG;
				end else
					nph = PH_DELTA;
			end
			PH_LOG2_FRAME: nph = PH_POC_TYPE;
			PH_POC_TYPE: nph = (dv == 32'd0) ? PH_POC_LSB :
				(dv == 32'd1) ? PH_ZERO_FLAG : PH_NUM_REF;
			PH_POC_LSB: nph = PH_NUM_REF;
			PH_ZERO_FLAG: nph = PH_OFF_NONREF;
			PH_OFF_NONREF: nph = PH_OFF_TB;
			PH_OFF_TB: nph = PH_CYCLE_LEN;
			PH_CYCLE_LEN: begin
				cyc_load = 1'b1;
				nph = (dv == 32'd0) ? PH_NUM_REF : PH_CYCLE_OFF;
			end
			PH_CYCLE_OFF: begin
				cyc_dec = 1'b1;
				nph = (cycle_q == 32'd1) ? PH_NUM_REF : PH_CYCLE_OFF;
			end
			PH_NUM_REF: nph = PH_GAPS;
			PH_GAPS: nph = PH_WIDTH;
			PH_WIDTH: begin width_wr = 1'b1; nph = PH_HEIGHT; end
			PH_HEIGHT: begin height_wr = 1'b1; nph = PH_FRAME_ONLY; end
			PH_FRAME_ONLY: begin fo_wr = 1'b1; nph = dv[0] ? PH_DIRECT8 : PH_MBAFF; end
			PH_MBAFF: nph = PH_DIRECT8;
			PH_DIRECT8: nph = PH_CROP_FLAG;
			PH_CROP_FLAG: begin set_list0 = 1'b1; nph = dv[0] ? PH_CROP : PH_DONE; end
			PH_CROP: begin
				crop_wr = 1'b1; inc_list = 1'b1;
				nph = (nl >= 4'd4) ? PH_DONE : PH_CROP;
			end
			default: nph = PH_DONE;
		endcase
	end

	logic active, drain_ok, step_en;
	assign active  = err_q == 3'd0 && phase_q != PH_DONE;
	assign drain_ok = gol && bl_q == 6'd0 && gz_q == 6'd0;

	assign q_pop     = state_q == S_IDLE && q_valid;
	assign out_valid = out_full_q;
	assign out_data  = out_q;
	assign out_load  = state_q == S_CALC3 && (!out_full_q || !out_stall);

	always_comb step_en = (state_q == S_BITS && active) ||
		(state_q == S_DRAIN && active && drain_ok && phase_q != PH_CYCLE_OFF);

	always_comb begin
		res_n = '0;
		if (cur_q.short_unit) res_n.status = ST_TRUNC;
		else if (err_q != 3'd0) res_n.status = err_q;
		else if (big_s1) res_n.status = ST_OVERSIZE;
		else if (cx_s2 >= 36'(cw_s1) || cy_s2 >= 36'(ch_s1))
			res_n.status = ST_EMPTY;
		else begin
			res_n.status         = ST_OK;
			res_n.coded_width    = cw_s1;
			res_n.coded_height   = ch_s1;
			res_n.visible_width  = cw_s1 - cx_s2[13:0];
			res_n.visible_height = ch_s1 - cy_s2[14:0];
			res_n.crop_left_px   = lx_s2[12:0];
			res_n.crop_top_px    = ty_s2[13:0];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_data;
		if (state_q == S_CALC1) begin
			ux_s1  <= (chroma_q == 2'd1 || chroma_q == 2'd2) ? 2'd2 : 2'd1;
			uy_s1  <= (frame_only_q ? 3'd1 : 3'd2) << (chroma_q == 2'd1);
			sx_s1  <= {2'b0, crop_q[0]} + {2'b0, crop_q[1]};
			sy_s1  <= {2'b0, crop_q[2]} + {2'b0, crop_q[3]};
			big_s1 <= (33'(width_q) + 33'd1 > 33'(MAX_WIDTH_MBS)) ||
				(33'(height_q) + 33'd1 > 33'(MAX_HEIGHT_UNITS));
			cw_s1  <= 14'((width_q[12:0] + 13'd0 + 14'd1) << 4);
			ch_s1  <= 15'(((15'(height_q[12:0]) + 15'd1) << 4) << !frame_only_q);
		end
		if (state_q == S_CALC2) begin
			cx_s2 <= 36'(sx_s1) * 36'(ux_s1);
			cy_s2 <= 36'(sy_s1) * 36'(uy_s1);
			lx_s2 <= 36'(crop_q[0]) * 36'(ux_s1);
			ty_s2 <= 36'(crop_q[2]) * 36'(uy_s1);
		end
		if (out_load)
			out_q <= res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; bit_q <= 3'd7; out_full_q <= 1'b0;
			phase_q <= PH_PROFILE; gz_q <= '0; acc_q <= '0; bl_q <= 6'd8;
			profile_q <= '0; chroma_q <= 2'd1; frame_only_q <= 1'b0;
			list_q <= '0; entry_q <= '0; last_scale_q <= 8'd8; cycle_q <= '0;
			err_q <= '0;
		end else begin
			if (out_load) out_full_q <= 1'b1;
			else if (out_full_q && !out_stall) out_full_q <= 1'b0;
			case (state_q)
				S_IDLE: if (q_valid) begin
					bit_q <= 3'd7;
					state_q <= q_data.feed ? S_BITS : (q_data.last ? S_DRAIN : S_IDLE);
				end
				S_BITS, S_DRAIN: begin
					if (state_q == S_BITS) begin
						bit_q <= bit_q - 3'd1;
						if (bit_q == 3'd0)
							state_q <= cur_q.last ? S_DRAIN : S_IDLE;
					end else if (!active || cur_q.short_unit)
						state_q <= S_CALC1;
					else if (!drain_ok)
						err_q <= ST_TRUNC;
					else if (phase_q == PH_CYCLE_OFF) begin
						phase_q <= PH_NUM_REF; bl_q <= 6'd0; gz_q <= '0; acc_q <= '0;
					end
					if (step_en && state_q == S_BITS && !dlv) begin
						if (!gol) begin
							acc_q <= acc_sh; bl_q <= bl_q - 6'd1;
						end else if (bl_q == 6'd0) begin
							if (!b) begin
								gz_q <= gz_q + 6'd1;
								if (gz_q + 6'd1 > 6'(MAX_GOLOMB_ZEROS)) err_q <= ST_LONG_CODE;
							end else begin
								bl_q <= gz_q; acc_q <= '0;
							end
						end else begin
							acc_q <= acc_sh; bl_q <= bl_q - 6'd1;
						end
					end
					if (step_en && (dlv || state_q == S_DRAIN)) begin
						phase_q <= nph;
						bl_q  <= {2'b0, phase_width(nph)};
						gz_q  <= '0;
						acc_q <= '0;
						if (prof_wr) profile_q <= dv[7:0];
						if (chroma_wr) chroma_q <= (dv <= 32'd3) ? dv[1:0] : 2'd0;
						if (fo_wr) frame_only_q <= dv[0];
						if (set_list0) list_q <= '0;
						if (inc_list) list_q <= nl;
						if (set_scale) begin entry_q <= '0; last_scale_q <= 8'd8; end
						if (ent_inc) begin
							entry_q <= entry_q + 7'd1;
							if (ns != 8'd0) last_scale_q <= ns;
						end
						if (cyc_load) cycle_q <= dv;
						if (cyc_dec) cycle_q <= cycle_q - 32'd1;
					end
				end
				S_CALC1: state_q <= S_CALC2;
				S_CALC2: state_q <= S_CALC3;
				S_CALC3: if (out_load) begin
					state_q <= S_IDLE;
					phase_q <= PH_PROFILE; gz_q <= '0; acc_q <= '0; bl_q <= 6'd8;
					profile_q <= '0; chroma_q <= 2'd1; frame_only_q <= 1'b0;
					list_q <= '0; entry_q <= '0; last_scale_q <= 8'd8; cycle_q <= '0;
					err_q <= '0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// crop and size registers clear at unit end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= '0; height_q <= '0;
			crop_q[0] <= '0; crop_q[1] <= '0; crop_q[2] <= '0; crop_q[3] <= '0;
		end else if (out_load) begin
			width_q <= '0; height_q <= '0;
			crop_q[0] <= '0; crop_q[1] <= '0; crop_q[2] <= '0; crop_q[3] <= '0;
		end else if (step_en) begin
			if (crop_wr) crop_q[list_q[1:0]] <= dv;
			if (width_wr) width_q <= dv;
			if (height_wr) height_q <= dv;
		end
	end
endmodule
`default_nettype wire

[rtl/core/h264_sps_dimension_parser_unit.sv]
// Top level of the H.264 SPS dimension parser.
//  port group    dir  payload      handshake
//  in_*          in   in_beat_t    in_valid / in_stall
//  out_*         out  out_beat_t   out_valid / out_stall
// A kept byte is popped from the queue, then read one bit per cycle by the
// Exp-Golomb reader; a dropped byte is only popped. The last byte adds a
// drain and size arithmetic in S_CALC1 to S_CALC3. The queue holds 4 beats;
// out_stall holds the result register. Reset returns all state to unit start.
`default_nettype none
module h264_sps_dimension_parser_unit import h264sps_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  in_beat_t  in_data,
	output logic      in_stall,
	output logic      out_valid,
	output out_beat_t out_data,
	input  wire logic out_stall
);
	logic  f_valid, f_full, b_valid, b_pop;
	work_t f_data, b_data;

	h264sps_front u_front (
		.clk, .arst_n, .in_valid, .in_data, .in_stall,
		.q_valid(f_valid), .q_data(f_data), .q_full(f_full)
	);

	h264sps_fifo u_fifo (
		.clk, .arst_n, .wr_en(f_valid), .wr_data(f_data), .full(f_full),
		.rd_valid(b_valid), .rd_data(b_data), .rd_en(b_pop)
	);

	h264sps_back u_back (
		.clk, .arst_n, .q_valid(b_valid), .q_data(b_data), .q_pop(b_pop),
		.out_valid, .out_data, .out_stall
	);
endmodule
`default_nettype wire
